// ===== rtl/sactd_pkg.sv =====
// ============================================================================
// sactd_pkg: shared types and constants of the cache tag directory
// Register indexes, replacement policy codes, field widths, controller
// states and the command and status bundles between controller and datapath.
// ============================================================================
package sactd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int OFF_W      = 5;
    localparam int IDX_W      = 4;
    localparam int WAYS_W     = 4;
    localparam int POL_W      = 2;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 32;
    localparam int WAY_OUT_W  = 3;
    localparam int LFSR_W     = 16;
    localparam int REM_STEPS  = 8;

    localparam logic [OFF_W-1:0]  OFF_MAX   = 5'd16;
    localparam logic [OFF_W-1:0]  OFF_RST   = 5'd4;
    localparam logic [IDX_W-1:0]  IDX_RST   = 4'd8;
    localparam logic [WAYS_W-1:0] WAYS_RST  = 4'd1;
    localparam logic [POL_W-1:0]  POL_RST   = 2'd1;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POL_W-1:0] POL_LRU  = 2'd1;
    localparam logic [POL_W-1:0] POL_RAND = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET = 2'd0,
        CFG_INDEX  = 2'd1,
        CFG_WAYS   = 2'd2,
        CFG_POLICY = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic lookup;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic commit_ok;
    } t_sts;

    // taps 16,14,13,11, shifting right
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic b;
        b = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {b, v[LFSR_W-1:1]};
    endfunction

endpackage

// ===== rtl/sactd_rem.sv =====
// ============================================================================
// sactd_rem: remainder of the next LFSR value by the ways in use
// Restoring remainder, REM_STEPS bits per cycle, upper half first then lower.
// Restarts by itself whenever the value or the divisor changes.
// ============================================================================
module sactd_rem
    import sactd_pkg::*;
#(
    parameter int DIV_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LFSR_W-1:0] i_value,
    input  logic [DIV_W-1:0]  i_div,
    output logic [DIV_W-1:0]  o_rem,
    output logic              o_done
);

    logic [LFSR_W-1:0]    r_src;
    logic [DIV_W-1:0]     r_div;
    logic [DIV_W-1:0]     r_rem;
    logic [REM_STEPS-1:0] r_lo;
    logic                 r_done;

    logic                 restart;
    logic [DIV_W-1:0]     p_rem_in;
    logic [REM_STEPS-1:0] p_bits;
    logic [DIV_W-1:0]     n_rem;

    assign restart = (i_value != r_src) || (i_div != r_div);

    always_comb begin
        logic [DIV_W:0] t;
        p_rem_in = restart ? '0 : r_rem;
        p_bits   = restart ? i_value[LFSR_W-1 -: REM_STEPS] : r_lo;
        n_rem    = p_rem_in;
        for (int k = 0; k < REM_STEPS; k++) begin
            t = {n_rem, p_bits[REM_STEPS-1-k]};
            if (t >= {1'b0, i_div}) begin
                t = t - {1'b0, i_div};
            end
            n_rem = t[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src  <= '0;
            r_div  <= '0;
            r_done <= 1'b0;
        end else if (restart) begin
            r_src  <= i_value;
            r_div  <= i_div;
            r_done <= 1'b0;
        end else if (!r_done) begin
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (restart) begin
            r_lo  <= i_value[REM_STEPS-1:0];
            r_rem <= n_rem;
        end else if (!r_done) begin
            r_rem <= n_rem;
        end
    end

    assign o_rem  = r_rem;
    assign o_done = r_done && !restart;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rem < i_div))
        else $error("remainder not below divisor");

endmodule

// ===== rtl/sactd_dp.sv =====
// ============================================================================
// sactd_dp: datapath of the cache tag directory
// Configuration registers, address split, set memories, hit and victim
// selection, age and pointer update, LFSR, counters and result registers.
// ============================================================================
module sactd_dp
    import sactd_pkg::*;
#(
    parameter int SETS      = 256,
    parameter int WAYS      = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [ADDR_BITS-1:0]  i_address,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_hit,
    output logic [WAY_OUT_W-1:0]  o_way,
    output logic                  o_evicted,
    output logic [TAG_W-1:0]      o_evicted_tag,
    output logic [CNT_W-1:0]      o_hit_count,
    output logic [CNT_W-1:0]      o_miss_count
);

    localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W = $clog2(WAYS + 1);
    localparam int MIB  = $clog2(SETS + 1) - 1;

    // configuration
    logic [OFF_W-1:0]  r_off;
    logic [IDX_W-1:0]  r_idx;
    logic [WAYS_W-1:0] r_ways;
    logic [POL_W-1:0]  r_policy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off    <= OFF_RST;
            r_idx    <= IDX_RST;
            r_ways   <= WAYS_RST;
            r_policy <= POL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET: r_off    <= i_cfg_data[OFF_W-1:0];
                CFG_INDEX:  r_idx    <= i_cfg_data[IDX_W-1:0];
                CFG_WAYS:   r_ways   <= i_cfg_data[WAYS_W-1:0];
                CFG_POLICY: r_policy <= i_cfg_data[POL_W-1:0];
                default: ;
            endcase
        end
    end

    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] ib;
    logic [NW_W-1:0]  nw;

    always_comb begin
        off = (r_off > OFF_MAX) ? OFF_MAX : r_off;
        ib  = (int'(r_idx) > MIB) ? IDX_W'(MIB) : r_idx;
        if (r_ways == '0) begin
            nw = NW_W'(1);
        end else if (int'(r_ways) > WAYS) begin
            nw = NW_W'(WAYS);
        end else begin
            nw = NW_W'(r_ways);
        end
    end

    // address split
    logic [ADDR_BITS+TAG_W-1:0] a_ext;
    logic [ADDR_BITS+TAG_W-1:0] sh_set;
    logic [ADDR_BITS+TAG_W-1:0] sh_tag;
    logic [OFF_W:0]             sh_amt;
    logic [SW-1:0]              set_mask;
    logic [SW-1:0]              l_set;
    logic [TAG_W-1:0]           l_tag;

    always_comb begin
        a_ext  = {{TAG_W{1'b0}}, i_address};
        sh_amt = {1'b0, off} + (OFF_W+1)'(ib);
        sh_set = a_ext >> off;
        sh_tag = a_ext >> sh_amt;
        for (int i = 0; i < SW; i++) begin
            set_mask[i] = (i < int'(ib));
        end
        l_set = sh_set[SW-1:0] & set_mask;
        l_tag = sh_tag[TAG_W-1:0];
    end

    // set memories
    logic [WAYS-1:0][TAG_W-1:0] tag_mem [SETS];
    logic [WAYS-1:0]            vld_mem [SETS];
    logic [WAYS-1:0][AW-1:0]    age_mem [SETS];
    logic [AW-1:0]              ptr_mem [SETS];

    logic [WAYS-1:0][TAG_W-1:0] r_tag_row;
    logic [WAYS-1:0]            r_vld_row;
    logic [WAYS-1:0][AW-1:0]    r_age_row;
    logic [AW-1:0]              r_ptr_row;
    logic [SW-1:0]              r_set;
    logic [TAG_W-1:0]           r_tag;
    logic [SW-1:0]              r_clr;

    logic [WAYS-1:0][TAG_W-1:0] n_tag_row;
    logic [WAYS-1:0]            n_vld;
    logic [WAYS-1:0][AW-1:0]    n_age;
    logic [AW-1:0]              n_ptr;

    logic                       u_found;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_tag_row <= tag_mem[l_set];
            r_vld_row <= vld_mem[l_set];
            r_age_row <= age_mem[l_set];
            r_ptr_row <= ptr_mem[l_set];
            r_set     <= l_set;
            r_tag     <= l_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !u_found) begin
            tag_mem[r_set] <= n_tag_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            vld_mem[r_clr] <= '0;
            age_mem[r_clr] <= '0;
            ptr_mem[r_clr] <= '0;
        end else if (i_cmd.commit) begin
            vld_mem[r_set] <= n_vld;
            age_mem[r_set] <= n_age;
            ptr_mem[r_set] <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // random victim
    logic [LFSR_W-1:0] r_lfsr;
    logic [LFSR_W-1:0] lfsr_nxt;
    logic [NW_W-1:0]   rem;
    logic              rem_done;

    assign lfsr_nxt = lfsr_next(r_lfsr);

    sactd_rem #(
        .DIV_W (NW_W)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (lfsr_nxt),
        .i_div   (nw),
        .o_rem   (rem),
        .o_done  (rem_done)
    );

    // lookup and victim selection
    logic [WAYS-1:0] u_inuse;
    logic [WAYS-1:0] u_hitvec;
    logic [WAYS-1:0] u_invvec;
    logic            u_has_inv;
    logic [AW-1:0]   u_hit_way;
    logic [AW-1:0]   u_inv_way;
    logic [AW-1:0]   u_lru_way;
    logic [AW-1:0]   u_fifo_way;
    logic [AW-1:0]   u_fifo_nxt;
    logic [AW-1:0]   u_victim;
    logic [AW-1:0]   u_way;
    logic            u_evict;
    logic            u_rand_step;
    logic [TAG_W-1:0] u_evtag;

    always_comb begin
        logic [AW-1:0] best;
        for (int w = 0; w < WAYS; w++) begin
            u_inuse[w]  = (w < int'(nw));
            u_hitvec[w] = u_inuse[w] && r_vld_row[w] && (r_tag_row[w] == r_tag);
            u_invvec[w] = u_inuse[w] && !r_vld_row[w];
        end
        u_found   = |u_hitvec;
        u_has_inv = |u_invvec;
        u_hit_way = '0;
        u_inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (u_hitvec[w]) u_hit_way = AW'(w);
            if (u_invvec[w]) u_inv_way = AW'(w);
        end
        best      = '0;
        u_lru_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (u_inuse[w] && (r_age_row[w] > best)) begin
                best      = r_age_row[w];
                u_lru_way = AW'(w);
            end
        end
        u_fifo_way = (NW_W'(r_ptr_row) >= nw) ? '0 : r_ptr_row;
        u_fifo_nxt = ((NW_W'(u_fifo_way) + NW_W'(1)) == nw) ? '0 : u_fifo_way + 1'b1;
        u_evict    = !u_found && !u_has_inv;
        u_rand_step = 1'b0;
        case (r_policy)
            POL_FIFO: u_victim = u_fifo_way;
            POL_LRU:  u_victim = u_lru_way;
            default: begin
                u_victim    = rem[AW-1:0];
                u_rand_step = u_evict;
            end
        endcase
        if (u_found) begin
            u_way = u_hit_way;
        end else if (u_has_inv) begin
            u_way = u_inv_way;
        end else begin
            u_way = u_victim;
        end
        u_evtag = u_evict ? r_tag_row[u_way] : '0;
    end

    // row update
    always_comb begin
        logic [AW-1:0] a_hit;
        logic          inc;
        a_hit     = r_age_row[u_way];
        n_tag_row = r_tag_row;
        n_vld     = r_vld_row;
        n_age     = r_age_row;
        for (int w = 0; w < WAYS; w++) begin
            inc = (w != int'(u_way)) && r_vld_row[w] && u_inuse[w] &&
                  (u_found ? (r_age_row[w] < a_hit)
                           : (NW_W'(r_age_row[w]) < (nw - NW_W'(1))));
            if (inc) n_age[w] = r_age_row[w] + 1'b1;
        end
        n_age[u_way] = '0;
        if (!u_found) begin
            n_vld[u_way]     = 1'b1;
            n_tag_row[u_way] = r_tag;
        end
        n_ptr = (u_evict && (r_policy == POL_FIFO)) ? u_fifo_nxt : r_ptr_row;
    end

    // LFSR and counters
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr   <= LFSR_SEED;
            r_hits   <= '0;
            r_misses <= '0;
        end else if (i_cmd.commit) begin
            if (u_rand_step) r_lfsr <= lfsr_nxt;
            if (u_found) begin
                if (r_hits != '1) r_hits <= r_hits + 1'b1;
            end else begin
                if (r_misses != '1) r_misses <= r_misses + 1'b1;
            end
        end
    end

    // result registers
    logic                 r_hit;
    logic [WAY_OUT_W-1:0] r_way;
    logic                 r_evicted;
    logic [TAG_W-1:0]     r_evtag;
    logic [AW+WAY_OUT_W-1:0] way_ext;

    assign way_ext = {{WAY_OUT_W{1'b0}}, u_way};

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit     <= u_found;
            r_way     <= way_ext[WAY_OUT_W-1:0];
            r_evicted <= u_evict;
            r_evtag   <= u_evtag;
        end
    end

    assign o_hit         = r_hit;
    assign o_way         = r_way;
    assign o_evicted     = r_evicted;
    assign o_evicted_tag = r_evtag;
    assign o_hit_count   = r_hits;
    assign o_miss_count  = r_misses;

    assign o_sts.clr_last  = (r_clr == SW'(SETS - 1));
    assign o_sts.commit_ok = !u_rand_step || rem_done;

    a_hits_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_hits >= $past(r_hits)))
        else $error("hit count went down");

endmodule

// ===== rtl/sactd_ctrl.sv =====
// ============================================================================
// sactd_ctrl: controller of the cache tag directory
// Clearing pass after reset, lookup on accept, commit when the result
// register is free and a random victim ready, and the output valid flag.
// ============================================================================
module sactd_ctrl
    import sactd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:   if (i_valid) n_state = S_UPDATE;
            S_UPDATE: if (out_free && i_sts.commit_ok) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.lookup = i_valid;
            end
            S_UPDATE: o_cmd.commit = out_free && i_sts.commit_ok;
            default: ;
        endcase
        n_out_valid = o_cmd.commit || (r_out_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    a_lookup_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_UPDATE))
        else $error("accepted item not followed by update");

    a_valid_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_cmd.commit))
        else $error("result shown without commit");

endmodule

// ===== rtl/set_assoc_cache_tag_directory_top.sv =====
// ============================================================================
// set_assoc_cache_tag_directory_top: set-associative cache tag directory
// Looks up one byte address per item, reports hit way or filled way, the
// evicted tag and saturating hit and miss counts; FIFO, LRU or random.
// ============================================================================
// Items are taken one at a time. The set row is read from synchronous
// memory in the accept cycle, then compared, replaced and written back in
// the update state, which waits while the output register is full and not
// taken. A random replacement also waits on the remainder unit when its
// item is accepted right after an earlier random replacement or a ways
// write. After reset a clearing pass over all SETS sets (256 by default)
// zeroes valid bits, ages and pointers; no item is accepted meanwhile.
// Results wait in an output register, so the next item is taken meanwhile.
module set_assoc_cache_tag_directory_top
    import sactd_pkg::*;
#(
    parameter int SETS      = 256,
    parameter int WAYS      = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ADDR_BITS-1:0]  i_address,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_hit,
    output logic [WAY_OUT_W-1:0]  o_way,
    output logic                  o_evicted,
    output logic [TAG_W-1:0]      o_evicted_tag,
    output logic [CNT_W-1:0]      o_hit_count,
    output logic [CNT_W-1:0]      o_miss_count,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    sactd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    sactd_dp #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_address     (i_address),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_hit         (o_hit),
        .o_way         (o_way),
        .o_evicted     (o_evicted),
        .o_evicted_tag (o_evicted_tag),
        .o_hit_count   (o_hit_count),
        .o_miss_count  (o_miss_count)
    );

endmodule

// ===== verif/set_assoc_cache_tag_directory_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// set_assoc_cache_tag_directory_top_tb: cache tag directory testbench
// Drives byte addresses through the valid/ready input channel and checks
// every lookup result against a cycle-free predictor of the tag directory:
// hit or fill way, eviction, evicted tag and the running hit/miss counts.
// Runs directed corner cases, then random address streams with locality
// under changing geometry and replacement policy and several idle mixes.
// ============================================================================
module set_assoc_cache_tag_directory_top_tb;
    import sactd_pkg::*;

    localparam int SETS       = 256;
    localparam int WAYS       = 8;
    localparam int ADDR_BITS  = 32;
    localparam int LINES      = SETS * WAYS;
    localparam int MAX_IB     = $clog2(SETS + 1) - 1;
    localparam int SETTLE     = 4;
    localparam int N_PHASES   = 12;
    localparam int PHASE_LEN  = 70;
    localparam int TIMEOUT_NS = 2000000;

    localparam logic [POL_W-1:0] POL_UNDEF = 2'd3;

    typedef enum logic [1:0] {
        ST_LOOKUP,
        ST_CFG,
        ST_DRAIN,
        ST_MODE
    } t_step_kind;

    typedef struct packed {
        t_step_kind            kind;
        logic [31:0]           addr;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
        logic [6:0]            send_pct;
        logic [6:0]            recv_pct;
    } t_step;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way;
        logic        evicted;
        logic [31:0] evicted_tag;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
    } t_lookup_res;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    logic [ADDR_BITS-1:0]  i_address  = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    logic                  o_hit;
    logic [WAY_OUT_W-1:0]  o_way;
    logic                  o_evicted;
    logic [TAG_W-1:0]      o_evicted_tag;
    logic [CNT_W-1:0]      o_hit_count;
    logic [CNT_W-1:0]      o_miss_count;
    logic                  i_cfg_we   = 1'b0;
    t_cfg_idx              i_cfg_idx  = CFG_OFFSET;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    set_assoc_cache_tag_directory_top #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_address     (i_address),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_way         (o_way),
        .o_evicted     (o_evicted),
        .o_evicted_tag (o_evicted_tag),
        .o_hit_count   (o_hit_count),
        .o_miss_count  (o_miss_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [OFF_W-1:0]  m_off  = OFF_RST;
    logic [IDX_W-1:0]  m_idx  = IDX_RST;
    logic [WAYS_W-1:0] m_ways = WAYS_RST;
    logic [POL_W-1:0]  m_pol  = POL_RST;
    bit                line_vld   [LINES];
    logic [31:0]       line_tag_m [LINES];
    bit   [2:0]        way_age    [LINES];
    bit   [2:0]        fifo_ptr   [SETS];
    logic [15:0]       m_lfsr     = LFSR_SEED;
    logic [31:0]       m_hits     = '0;
    logic [31:0]       m_misses   = '0;

    t_step       step_q[$];
    t_lookup_res lookup_exp_q[$];

    logic        addr_taken = 1'b0;
    int          send_pct   = 0;
    int          recv_pct   = 0;
    int          settle_cnt = 0;
    int          n_errors   = 0;
    int          n_checked  = 0;
    int          n_hits_seen = 0;
    int          n_evicts   = 0;
    int          n_cfg      = 0;

    function automatic t_lookup_res predict_lookup(input logic [31:0] addr);
        int unsigned off, ib, nw, set_i, base, w, way, p;
        logic [31:0] tag_v;
        bit   [2:0]  a, best;
        bit          found;
        t_lookup_res r;
        off   = (m_off > OFF_MAX) ? OFF_MAX : m_off;
        ib    = (m_idx > MAX_IB) ? MAX_IB : m_idx;
        nw    = (m_ways == 0) ? 1 : ((m_ways > WAYS) ? WAYS : m_ways);
        set_i = (addr >> off) & ((32'd1 << ib) - 1);
        tag_v = addr >> (off + ib);
        base  = set_i * WAYS;
        found = 1'b0;
        way   = 0;
        r     = '0;
        for (w = 0; w < nw; w++) begin
            if (!found && line_vld[base+w] && line_tag_m[base+w] == tag_v) begin
                found = 1'b1;
                way   = w;
            end
        end
        if (found) begin
            a     = way_age[base+way];
            r.hit = 1'b1;
            if (m_hits != '1) m_hits++;
            for (w = 0; w < nw; w++) begin
                if (w != way && line_vld[base+w] && way_age[base+w] < a)
                    way_age[base+w]++;
            end
            way_age[base+way] = 0;
        end else begin
            if (m_misses != '1) m_misses++;
            for (w = 0; w < nw; w++) begin
                if (!found && !line_vld[base+w]) begin
                    found = 1'b1;
                    way   = w;
                end
            end
            if (!found) begin
                case (m_pol)
                    POL_FIFO: begin
                        p = fifo_ptr[set_i];
                        if (p >= nw) p = 0;
                        way = p;
                        fifo_ptr[set_i] = 3'((p + 1) % nw);
                    end
                    POL_LRU: begin
                        best = 0;
                        way  = 0;
                        for (w = 0; w < nw; w++) begin
                            if (way_age[base+w] > best) begin
                                best = way_age[base+w];
                                way  = w;
                            end
                        end
                    end
                    default: begin
                        m_lfsr = {m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5], m_lfsr[15:1]};
                        way    = m_lfsr % nw;
                    end
                endcase
                r.evicted     = 1'b1;
                r.evicted_tag = line_tag_m[base+way];
            end
            for (w = 0; w < nw; w++) begin
                if (w != way && line_vld[base+w] && way_age[base+w] < nw - 1)
                    way_age[base+w]++;
            end
            way_age[base+way]    = 0;
            line_vld[base+way]   = 1'b1;
            line_tag_m[base+way] = tag_v;
        end
        r.way        = way[2:0];
        r.hit_count  = m_hits;
        r.miss_count = m_misses;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    // monitor: config shadow, input acceptance, result checking
    always @(posedge i_clk) begin
        t_lookup_res exp_r;
        if (i_rst_n) begin
            addr_taken <= i_valid && o_ready;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OFFSET: m_off  = i_cfg_data[OFF_W-1:0];
                    CFG_INDEX:  m_idx  = i_cfg_data[IDX_W-1:0];
                    CFG_WAYS:   m_ways = i_cfg_data[WAYS_W-1:0];
                    CFG_POLICY: m_pol  = i_cfg_data[POL_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                if (lookup_exp_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, got hit %b way %0d",
                             $time, o_hit, o_way);
                end else begin
                    exp_r = lookup_exp_q.pop_front();
                    check_field("hit", exp_r.hit, o_hit);
                    check_field("way", exp_r.way, o_way);
                    check_field("evicted", exp_r.evicted, o_evicted);
                    check_field("evicted_tag", exp_r.evicted_tag, o_evicted_tag);
                    check_field("hit_count", exp_r.hit_count, o_hit_count);
                    check_field("miss_count", exp_r.miss_count, o_miss_count);
                    n_checked++;
                    n_hits_seen += exp_r.hit;
                    n_evicts    += exp_r.evicted;
                end
            end
            if (i_valid && o_ready)
                lookup_exp_q = {lookup_exp_q, predict_lookup(i_address)};
        end
    end

    // driver
    always @(negedge i_clk) begin
        logic                  nxt_valid;
        logic [31:0]           nxt_addr;
        logic                  nxt_we;
        t_cfg_idx              nxt_idx;
        logic [CFG_DATA_W-1:0] nxt_data;
        t_step                 s;
        nxt_valid = i_valid;
        nxt_addr  = i_address;
        nxt_we    = 1'b0;
        nxt_idx   = i_cfg_idx;
        nxt_data  = i_cfg_data;
        if (i_rst_n) begin
            if (!(i_valid && !addr_taken)) begin
                nxt_valid = 1'b0;
                if (settle_cnt != 0) begin
                    settle_cnt--;
                end else if (step_q.size() != 0) begin
                    s = step_q[0];
                    case (s.kind)
                        ST_MODE: begin
                            send_pct = s.send_pct;
                            recv_pct = s.recv_pct;
                            s = step_q.pop_front();
                        end
                        ST_DRAIN: begin
                            if (lookup_exp_q.size() == 0) begin
                                settle_cnt = SETTLE;
                                s = step_q.pop_front();
                            end
                        end
                        ST_CFG: begin
                            nxt_we   = 1'b1;
                            nxt_idx  = s.idx;
                            nxt_data = s.data;
                            s = step_q.pop_front();
                        end
                        ST_LOOKUP: begin
                            if ($urandom_range(0, 99) >= send_pct) begin
                                nxt_valid = 1'b1;
                                nxt_addr  = s.addr;
                                s = step_q.pop_front();
                            end
                        end
                        default: ;
                    endcase
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_pct);
        end
        i_valid    <= nxt_valid;
        i_address  <= nxt_addr;
        i_cfg_we   <= nxt_we;
        i_cfg_idx  <= nxt_idx;
        i_cfg_data <= nxt_data;
    end

    task automatic push_lookup(input logic [31:0] addr);
        t_step s;
        s      = '0;
        s.kind = ST_LOOKUP;
        s.addr = addr;
        step_q = {step_q, s};
    endtask

    task automatic push_drain();
        t_step s;
        s      = '0;
        s.kind = ST_DRAIN;
        step_q = {step_q, s};
    endtask

    task automatic push_mode(input int sp, input int rp);
        t_step s;
        s          = '0;
        s.kind     = ST_MODE;
        s.send_pct = sp;
        s.recv_pct = rp;
        step_q     = {step_q, s};
    endtask

    task automatic push_cfg(input int off, input int idx, input int ways, input int pol);
        t_step s;
        push_drain();
        s      = '0;
        s.kind = ST_CFG;
        s.idx  = CFG_OFFSET;
        s.data = off;
        step_q = {step_q, s};
        s.idx  = CFG_INDEX;
        s.data = idx;
        step_q = {step_q, s};
        s.idx  = CFG_WAYS;
        s.data = ways;
        step_q = {step_q, s};
        s.idx  = CFG_POLICY;
        s.data = pol;
        step_q = {step_q, s};
        n_cfg++;
    endtask

    initial begin
        int          off, idx, ways, pol, eff_off, eff_ib;
        logic [31:0] a, t, sidx;
        push_mode(0, 0);
        // reset geometry, direct mapped: fill, hit, all-ones, conflict
        push_lookup(32'h0000_0000);
        push_lookup(32'h0000_0000);
        push_lookup(32'hFFFF_FFFF);
        push_lookup(32'h0000_1000);
        // no offset, single set, two ways, round-robin victims
        push_cfg(0, 0, 2, POL_FIFO);
        for (int k = 0; k < 4; k++) push_lookup(k);
        push_lookup(32'h0000_0000);
        // oversize offset, index and ways, undefined policy acts random
        push_cfg(31, 15, 15, POL_UNDEF);
        for (int k = 0; k < 9; k++) push_lookup(k << 24);
        push_cfg(16, 8, 8, POL_LRU);
        push_lookup(32'h0800_0000);
        push_lookup(32'h0B00_0000);
        // zero ways acts as direct mapped
        push_cfg(4, 4, 0, POL_RAND);
        push_lookup(32'hFFFF_FFF0);
        push_lookup(32'h1234_5678);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                off = 0; idx = 0; ways = 1; pol = POL_FIFO;
            end else if (p == 1) begin
                off = 31; idx = 15; ways = 15; pol = POL_UNDEF;
            end else begin
                off  = ($urandom_range(0, 7) == 0) ? 31 : $urandom_range(0, 20);
                idx  = ($urandom_range(0, 7) == 0) ? 15 : $urandom_range(0, 9);
                ways = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(2, 8);
                pol  = $urandom_range(0, 3);
            end
            push_cfg(off, idx, ways, pol);
            case (p % 4)
                0: push_mode(0, 0);
                1: push_mode(86, 0);
                2: push_mode(0, 86);
                default: push_mode(21, 21);
            endcase
            eff_off = (off > 16) ? 16 : off;
            eff_ib  = (idx > MAX_IB) ? MAX_IB : idx;
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (k == PHASE_LEN / 2) push_drain();
                if ($urandom_range(0, 99) < 15) begin
                    a = $urandom();
                end else begin
                    t    = $urandom_range(0, 11);
                    sidx = $urandom_range(0, 3) & ((32'd1 << eff_ib) - 1);
                    a    = (t << (eff_off + eff_ib)) | (sidx << eff_off)
                         | ($urandom() & ((32'd1 << eff_off) - 1));
                end
                push_lookup(a);
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (step_q.size() != 0 || i_valid || lookup_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (4 * SETTLE) @(posedge i_clk);

        if (lookup_exp_q.size() != 0) begin
            n_errors++;
            $display("%0t: %0d results never arrived", $time, lookup_exp_q.size());
        end
        $display("Checked %0d lookups over %0d configurations: %0d hits, %0d evictions.",
                 n_checked, n_cfg, n_hits_seen, n_evicts);
        $display("Policies FIFO, LRU, random; idle mixes none, sender, receiver, both.");
        if (n_errors == 0) begin
            $display("set_assoc_cache_tag_directory_top test passed");
        end else begin
            $display("set_assoc_cache_tag_directory_top test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("set_assoc_cache_tag_directory_top test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sactd_pkg.sv
rtl/sactd_rem.sv
rtl/sactd_dp.sv
rtl/sactd_ctrl.sv
rtl/set_assoc_cache_tag_directory_top.sv
verif/set_assoc_cache_tag_directory_top_tb.sv
